/* rtl/ipmac_pkg.sv */
// ----------------------------------------------------------------------------
// ipmac_pkg
// Shared types and constants for the IPv4-to-MAC resolution cache.
// ----------------------------------------------------------------------------
`default_nettype none

package ipmac_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned MAC_W       = 48;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_LEARN  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch request, start scan at entry 0
    logic advance;     // step to next entry
    logic finish_scan; // latch result of the scan
    logic upd_mac;     // overwrite MAC of matching entry
    logic insert;      // write ip/mac at round-robin slot
    logic out_load;    // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;       // current entry is filled and holds the key
    logic last;        // current entry is the last filled one (or table empty)
    logic is_learn;
    logic allow;
  } status_t;

endpackage

`default_nettype wire

/* rtl/ipmac_stream_if.sv */
// ----------------------------------------------------------------------------
// ipmac_req_if / ipmac_rsp_if
// Valid/ready channels for cache requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipmac_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] ip_addr;
  logic [47:0] mac_in;
  logic        allow_insert;

  modport source (output valid, action, ip_addr, mac_in, allow_insert, input ready);
  modport sink   (input valid, action, ip_addr, mac_in, allow_insert, output ready);
endinterface

interface ipmac_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [47:0] mac_out;

  modport source (output valid, hit, mac_out, input ready);
  modport sink   (input valid, hit, mac_out, output ready);
endinterface

`default_nettype wire

/* rtl/ipmac_ctrl.sv */
// ----------------------------------------------------------------------------
// ipmac_ctrl
// Sequencer: accepts an item, walks the table one entry per cycle, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipmac_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  input  wire ipmac_pkg::status_t status,
  output ipmac_pkg::cmd_t        cmd
);
  import ipmac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.match) begin
          cmd.finish_scan = 1'b1;
          cmd.upd_mac     = status.is_learn;
          state_next      = ST_FINISH;
        end else if (status.last) begin
          cmd.finish_scan = 1'b1;
          cmd.insert      = status.is_learn & status.allow;
          state_next      = ST_FINISH;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp_valid = out_valid;

endmodule

`default_nettype wire

/* rtl/ipmac_datapath.sv */
// ----------------------------------------------------------------------------
// ipmac_datapath
// Table memories, scan index, fill count, round-robin slot and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module ipmac_datapath #(
  parameter int unsigned ENTRIES = ipmac_pkg::ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        action,
  input  wire logic [ipmac_pkg::IP_W-1:0]  ip_addr,
  input  wire logic [ipmac_pkg::MAC_W-1:0] mac_in,
  input  wire logic                        allow_insert,
  input  wire ipmac_pkg::cmd_t             cmd,
  output ipmac_pkg::status_t               status,
  output logic                             hit,
  output logic [ipmac_pkg::MAC_W-1:0]      mac_out
);
  import ipmac_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  logic [IP_W-1:0]  ip_mem  [ENTRIES];
  logic [MAC_W-1:0] mac_mem [ENTRIES];

  logic             action_q;
  logic             allow_q;
  logic [IP_W-1:0]  key;
  logic [MAC_W-1:0] mac_key;

  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] next_slot;
  logic [CNT_W-1:0] fill_count;
  logic [IP_W-1:0]  rd_ip;
  logic [MAC_W-1:0] rd_mac;
  logic [IDX_W-1:0] wr_addr;

  logic             res_hit;
  logic [MAC_W-1:0] res_mac;

  // read address runs one step ahead so rd_* always belongs to idx
  always_comb begin
    idx_next = idx;
    if (cmd.load) begin
      idx_next = '0;
    end else if (cmd.advance) begin
      idx_next = idx + IDX_W'(1);
    end
  end

  assign wr_addr = cmd.insert ? next_slot : idx;

  always_ff @(posedge clk) begin
    rd_ip  <= ip_mem[idx_next];
    rd_mac <= mac_mem[idx_next];
    if (cmd.insert) begin
      ip_mem[wr_addr] <= key;
    end
    if (cmd.insert || cmd.upd_mac) begin
      mac_mem[wr_addr] <= mac_key;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.load) begin
      action_q <= action;
      allow_q  <= allow_insert;
      key      <= ip_addr;
      mac_key  <= mac_in;
    end
    if (cmd.finish_scan) begin
      res_hit <= status.match;
      res_mac <= (status.match && action_q == ACT_LOOKUP) ? rd_mac : '0;
    end
    if (cmd.out_load) begin
      hit     <= res_hit;
      mac_out <= res_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      next_slot  <= '0;
    end else if (cmd.insert) begin
      if (fill_count != CNT_W'(ENTRIES)) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      if (next_slot == IDX_W'(ENTRIES - 1)) begin
        next_slot <= '0;
      end else begin
        next_slot <= next_slot + IDX_W'(1);
      end
    end
  end

  // an empty table never reads as a match, so unwritten entries stay unseen
  assign status.match    = (fill_count != '0) && (rd_ip == key);
  assign status.last     = ((CNT_W + 1)'(idx) + (CNT_W + 1)'(1)) >= {1'b0, fill_count};
  assign status.is_learn = (action_q == ACT_LEARN);
  assign status.allow    = allow_q;

endmodule

`default_nettype wire

/* rtl/ip_to_mac_resolution_cache.sv */
// ----------------------------------------------------------------------------
// ip_to_mac_resolution_cache
// IPv4-to-MAC cache with first-match lookup/learn and round-robin insertion.
// ----------------------------------------------------------------------------
//  channel  direction  fields
//  req      in         action, ip_addr, mac_in, allow_insert
//  rsp      out        hit, mac_out
//
//  An item is accepted, then compared against k entries, k = 1 .. max(1,
//  fill count), then its result is loaded into the result register. The scan
//  reads the table one entry per cycle; the single write lands on the last
//  scan cycle.
//  Reset clears fill count and slot pointer; table contents need no reset.
//  A waiting result does not block the next item; a stalled rsp holds the
//  following item in its final cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_to_mac_resolution_cache #(
  parameter int unsigned ENTRIES = ipmac_pkg::ENTRIES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  ipmac_req_if.sink     req,
  ipmac_rsp_if.source   rsp
);
  import ipmac_pkg::*;

  cmd_t    cmd;
  status_t status;

  ipmac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ipmac_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .action       (req.action),
    .ip_addr      (req.ip_addr),
    .mac_in       (req.mac_in),
    .allow_insert (req.allow_insert),
    .cmd          (cmd),
    .status       (status),
    .hit          (rsp.hit),
    .mac_out      (rsp.mac_out)
  );

endmodule

`default_nettype wire
